/* hw/rtl/psnm_pkg.sv */
// Shared types, widths and codes for the probe step-noise monitor.
// Used by psnm_mul, psnm_div and probe_step_noise_monitor; depends on nothing.

package psnm_pkg;

    // Defaults for the top-level parameters.
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF   = 16;

    // Accumulator and register widths.
    localparam int WEIGHT_W    = 36;
    localparam int SUM_W       = 50;
    localparam int SQ_W        = 62;
    localparam int COUNT_W     = 20;
    localparam int DECAY_W     = 17;
    localparam int LIMIT_W     = 20;
    localparam int VAR_W       = 32;
    localparam int ACTION_W    = 2;
    localparam int VERDICT_W   = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    // The decay factor is Q1.16; the variance and the spread limit carry 8 fraction bits.
    localparam int DECAY_SHIFT = 16;
    localparam int VAR_FRAC    = 8;

    // Shared digit-serial multiplier.
    localparam int MUL_A_W     = 62;
    localparam int MUL_B_W     = 64;
    localparam int MUL_DIGIT_W = 16;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    // Restoring divider.
    localparam int DIV_D_W = 2 * WEIGHT_W;
    localparam int DIV_Q_W = VAR_W;

    // Register reset values.
    localparam logic [DECAY_W-1:0] DECAY_ONE          = 17'h10000;
    localparam logic [LIMIT_W-1:0] MIN_EVIDENCE_RESET = 20'd16;
    localparam logic [LIMIT_W-1:0] SPREAD_RESET       = 20'd2560;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_DECAY = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_UNKNOWN   = 2'd0,
        VERDICT_NOISY     = 2'd1,
        VERDICT_CONNECTED = 2'd2
    } verdict_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DECAY        = 2'd0,
        CFG_MIN_EVIDENCE = 2'd1,
        CFG_MAX_SPREAD   = 2'd2
    } cfg_index_t;

endpackage

/* hw/rtl/probe_step_noise_monitor.sv */
// Probe step-noise monitor: decayed running variance of reading steps and a probe verdict.
// Depends on psnm_pkg, psnm_mul and psnm_div.
//
// Usage:
// The input channel (in_valid, in_stall, action, reading) takes one transaction at a time:
// add a reading, decay the evidence or clear everything. Every input transaction gives
// exactly one output transaction (verdict, evidence_count, step_variance) on out_valid
// and out_stall. in_stall is high from the cycle after acceptance until the block is idle.
// An add, a clear or an unused action runs the five products of the evaluation on the
// shared 62x16 digit-serial multiplier; a decay first runs four more products on it to
// scale the evidence. Every transaction then passes through the 32-step divider, and the
// next one is taken once its result has been loaded into the output register. The result
// sits in an output register: the block accepts and works on the next transaction while
// the receiver stalls, and waits only when a new result is ready and the old one has not
// been taken. Reset clears the accumulators and the baseline and loads the register
// defaults (decay 1.0, min evidence 16, spread limit 10.0).
// Configuration writes (cfg_write, cfg_index, cfg_data) are taken in any cycle and must
// be made only while the block is idle.

module probe_step_noise_monitor #(
    parameter int SAMPLE_BITS = psnm_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = psnm_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [psnm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psnm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [psnm_pkg::ACTION_W-1:0]    action,
    input  logic [SAMPLE_BITS-1:0]           reading,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [psnm_pkg::VERDICT_W-1:0]   verdict,
    output logic [psnm_pkg::COUNT_W-1:0]     evidence_count,
    output logic [psnm_pkg::VAR_W-1:0]       step_variance
);
    import psnm_pkg::*;

    localparam int QW_W  = SQ_W + WEIGHT_W;
    localparam int SS_W  = 2 * SUM_W - 1;
    localparam int NUM_W = QW_W;
    localparam int WW_W  = 2 * WEIGHT_W;
    localparam int LW_W  = LIMIT_W + WEIGHT_W;
    localparam int LW2_W = 2 * LW_W;
    localparam int CMP_W = NUM_W + 2 * VAR_FRAC;
    localparam int X_W   = NUM_W + VAR_FRAC;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_BITS;
    localparam logic [WEIGHT_W-1:0] WEIGHT_TWO = WEIGHT_W'(2) << FRAC_BITS;
    localparam logic [SUM_W-1:0]    SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]    SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_UPDATE = 13'b0000000000010,
        ST_DW     = 13'b0000000000100,
        ST_DS     = 13'b0000000001000,
        ST_DQ     = 13'b0000000010000,
        ST_DC     = 13'b0000000100000,
        ST_QW     = 13'b0000001000000,
        ST_SS     = 13'b0000010000000,
        ST_WW     = 13'b0000100000000,
        ST_LW     = 13'b0001000000000,
        ST_LW2    = 13'b0010000000000,
        ST_DIV    = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   launch_reg;
    logic   launch_next;

    // Configuration registers.
    logic [DECAY_W-1:0] decay_reg;
    logic [LIMIT_W-1:0] min_ev_reg;
    logic [LIMIT_W-1:0] spread_reg;

    // Accumulated evidence.
    logic [SAMPLE_BITS-1:0] base_reg;
    logic                   base_valid_reg;
    logic [WEIGHT_W-1:0]    weight_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [COUNT_W-1:0]     count_reg;

    // Captured input transaction.
    action_t                action_reg;
    logic [SAMPLE_BITS-1:0] reading_reg;

    // Evaluation results.
    logic [QW_W-1:0]  qw_reg;
    logic [NUM_W-1:0] num_reg;
    logic             pos_reg;
    logic [WW_W-1:0]  ww_reg;
    logic [LW_W-1:0]  lw_reg;
    logic             noisy_reg;
    logic             sat_reg;

    // Output register.
    logic                 out_valid_reg;
    verdict_t             verdict_reg;
    logic [COUNT_W-1:0]   count_out_reg;
    logic [VAR_W-1:0]     var_out_reg;

    // Add-path arithmetic.
    logic signed [SAMPLE_BITS:0]  step_s;
    logic [SAMPLE_BITS-1:0]       step_mag;
    logic [2*SAMPLE_BITS-1:0]     step_sq;
    logic [SUM_W-1:0]             sum_inc;
    logic [SUM_W:0]               sum_wide;
    logic [SUM_W-1:0]             sum_add;
    logic [SQ_W:0]                sq_wide;
    logic [SQ_W-1:0]              sq_add;
    logic [WEIGHT_W:0]            weight_wide;
    logic [WEIGHT_W-1:0]          weight_add;
    logic [COUNT_W-1:0]           count_inc;

    // Decay and evaluation helpers.
    logic [DECAY_W-1:0] factor;
    logic               sum_neg;
    logic [SUM_W-1:0]   sum_mag;
    logic [SUM_W-1:0]   dec_mag;
    logic [SS_W-1:0]    ss_val;
    logic [SS_W-1:0]    qw_ext;
    logic [CMP_W-1:0]   num_scaled;
    logic [CMP_W-1:0]   lw2_ext;
    logic [X_W-1:0]     div_x;
    logic [X_W-1:0]     div_limit;
    logic               weight_ok;

    // Shared unit interface.
    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_p;
    logic               div_start;
    logic               div_done;
    logic [DIV_Q_W-1:0] div_q;

    logic in_accept;
    logic out_load;

    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // Step from the baseline and the saturating accumulator updates of an add.
    always_comb
    begin
        step_s      = $signed({1'b0, reading_reg}) - $signed({1'b0, base_reg});
        step_mag    = step_s[SAMPLE_BITS] ? SAMPLE_BITS'(-step_s) : step_s[SAMPLE_BITS-1:0];
        step_sq     = step_mag * step_mag;
        sum_inc     = {{(SUM_W-SAMPLE_BITS-1){step_s[SAMPLE_BITS]}}, step_s} << FRAC_BITS;
        sum_wide    = {sum_reg[SUM_W-1], sum_reg} + {sum_inc[SUM_W-1], sum_inc};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_add = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_add = sum_wide[SUM_W-1:0];
        end
        sq_wide     = {1'b0, sq_reg} + {1'b0, SQ_W'(step_sq) << FRAC_BITS};
        sq_add      = sq_wide[SQ_W] ? {SQ_W{1'b1}} : sq_wide[SQ_W-1:0];
        weight_wide = {1'b0, weight_reg} + {1'b0, WEIGHT_ONE};
        weight_add  = weight_wide[WEIGHT_W] ? {WEIGHT_W{1'b1}} : weight_wide[WEIGHT_W-1:0];
        count_inc   = (count_reg == {COUNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;
    end

    // Decay factor clamp, sum magnitude and the wide compares of the evaluation.
    always_comb
    begin
        factor     = (decay_reg > DECAY_ONE) ? DECAY_ONE : decay_reg;
        sum_neg    = sum_reg[SUM_W-1];
        sum_mag    = sum_neg ? (~sum_reg + 1'b1) : sum_reg;
        dec_mag    = mul_p[DECAY_SHIFT +: SUM_W];
        ss_val     = mul_p[SS_W-1:0];
        qw_ext     = SS_W'(qw_reg);
        num_scaled = {num_reg, {(2*VAR_FRAC){1'b0}}};
        lw2_ext    = CMP_W'(mul_p[LW2_W-1:0]);
        div_x      = {num_reg, {VAR_FRAC{1'b0}}};
        div_limit  = X_W'({ww_reg, {VAR_W{1'b0}}});
        weight_ok  = (weight_reg >= WEIGHT_TWO);
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_DW:
            begin
                mul_a = MUL_A_W'(weight_reg);
                mul_b = MUL_B_W'(factor);
            end
            ST_DS:
            begin
                mul_a = MUL_A_W'(sum_mag);
                mul_b = MUL_B_W'(factor);
            end
            ST_DQ:
            begin
                mul_a = MUL_A_W'(sq_reg);
                mul_b = MUL_B_W'(factor);
            end
            ST_DC:
            begin
                mul_a = MUL_A_W'(count_reg);
                mul_b = MUL_B_W'(factor);
            end
            ST_QW:
            begin
                mul_a = MUL_A_W'(sq_reg);
                mul_b = MUL_B_W'(weight_reg);
            end
            ST_SS:
            begin
                mul_a = MUL_A_W'(sum_mag);
                mul_b = MUL_B_W'(sum_mag);
            end
            ST_WW:
            begin
                mul_a = MUL_A_W'(weight_reg);
                mul_b = MUL_B_W'(weight_reg);
            end
            ST_LW:
            begin
                mul_a = MUL_A_W'(weight_reg);
                mul_b = MUL_B_W'(spread_reg);
            end
            ST_LW2:
            begin
                mul_a = MUL_A_W'(lw_reg);
                mul_b = MUL_B_W'(lw_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = launch_reg && (state_reg != ST_DIV);
    assign div_start = launch_reg && (state_reg == ST_DIV);

    psnm_mul #(
        .A_W     (MUL_A_W),
        .B_W     (MUL_B_W),
        .DIGIT_W (MUL_DIGIT_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    psnm_div #(
        .D_W (DIV_D_W),
        .Q_W (DIV_Q_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .rem_init    (div_x[VAR_W +: DIV_D_W]),
        .dividend_lo (div_x[VAR_W-1:0]),
        .divisor     (ww_reg),
        .done        (div_done),
        .quotient    (div_q)
    );

    // Sequencer: update, optional decay passes, five products, divide, output.
    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next  = (action_reg == ACT_DECAY) ? ST_DW : ST_QW;
                launch_next = 1'b1;
            end
            ST_DW, ST_DS, ST_DQ, ST_DC, ST_QW, ST_SS, ST_WW, ST_LW, ST_LW2:
            begin
                if (mul_done)
                begin
                    launch_next = 1'b1;
                    case (state_reg)
                        ST_DW:   state_next = ST_DS;
                        ST_DS:   state_next = ST_DQ;
                        ST_DQ:   state_next = ST_DC;
                        ST_DC:   state_next = ST_QW;
                        ST_QW:   state_next = ST_SS;
                        ST_SS:   state_next = ST_WW;
                        ST_WW:   state_next = ST_LW;
                        ST_LW:   state_next = ST_LW2;
                        default: state_next = ST_DIV;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    // Configuration writes; indexes past the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg  <= DECAY_ONE;
            min_ev_reg <= MIN_EVIDENCE_RESET;
            spread_reg <= SPREAD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DECAY:        decay_reg  <= cfg_data[DECAY_W-1:0];
                CFG_MIN_EVIDENCE: min_ev_reg <= cfg_data[LIMIT_W-1:0];
                CFG_MAX_SPREAD:   spread_reg <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Capture of the accepted input transaction.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg  <= action_t'(action);
            reading_reg <= reading;
        end
    end

    // Evidence state: add and clear in the update cycle, decay through the multiplier.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            base_valid_reg <= 1'b0;
            weight_reg     <= '0;
            sum_reg        <= '0;
            sq_reg         <= '0;
            count_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_UPDATE:
                begin
                    case (action_reg)
                        ACT_ADD:
                        begin
                            if (base_valid_reg)
                            begin
                                weight_reg <= weight_add;
                                sum_reg    <= sum_add;
                                sq_reg     <= sq_add;
                            end
                            base_reg       <= reading_reg;
                            base_valid_reg <= 1'b1;
                            count_reg      <= count_inc;
                        end
                        ACT_CLEAR:
                        begin
                            base_reg       <= '0;
                            base_valid_reg <= 1'b0;
                            weight_reg     <= '0;
                            sum_reg        <= '0;
                            sq_reg         <= '0;
                            count_reg      <= '0;
                        end
                        default: ;
                    endcase
                end
                ST_DW:
                begin
                    if (mul_done)
                    begin
                        weight_reg <= mul_p[DECAY_SHIFT +: WEIGHT_W];
                    end
                end
                ST_DS:
                begin
                    if (mul_done)
                    begin
                        sum_reg <= sum_neg ? (~dec_mag + 1'b1) : dec_mag;
                    end
                end
                ST_DQ:
                begin
                    if (mul_done)
                    begin
                        sq_reg <= mul_p[DECAY_SHIFT +: SQ_W];
                    end
                end
                ST_DC:
                begin
                    if (mul_done)
                    begin
                        count_reg <= mul_p[DECAY_SHIFT +: COUNT_W];
                    end
                end
                default: ;
            endcase
        end
    end

    // Products and compares of the variance evaluation.
    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            case (state_reg)
                ST_QW:
                begin
                    qw_reg <= mul_p[QW_W-1:0];
                end
                ST_SS:
                begin
                    pos_reg <= weight_ok && (qw_ext > ss_val);
                    num_reg <= qw_reg - ss_val[NUM_W-1:0];
                end
                ST_WW:
                begin
                    ww_reg <= mul_p[WW_W-1:0];
                end
                ST_LW:
                begin
                    lw_reg <= mul_p[LW_W-1:0];
                end
                ST_LW2:
                begin
                    noisy_reg <= pos_reg && (lw2_ext < num_scaled);
                end
                default: ;
            endcase
        end
        if (div_start)
        begin
            sat_reg <= (div_x >= div_limit);
        end
    end

    // Output register: loads a new result whenever the previous one has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (count_reg < min_ev_reg)
            begin
                verdict_reg <= VERDICT_UNKNOWN;
            end
            else if (noisy_reg)
            begin
                verdict_reg <= VERDICT_NOISY;
            end
            else
            begin
                verdict_reg <= VERDICT_CONNECTED;
            end
            count_out_reg <= count_reg;
            if (!pos_reg)
            begin
                var_out_reg <= '0;
            end
            else if (sat_reg)
            begin
                var_out_reg <= {VAR_W{1'b1}};
            end
            else
            begin
                var_out_reg <= div_q;
            end
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign evidence_count = count_out_reg;
    assign step_variance  = var_out_reg;

endmodule

/* hw/rtl/psnm_mul.sv */
// Digit-serial unsigned multiplier: one wide operand times one 16-bit digit per cycle.
// Depends on psnm_pkg for its default widths.

module psnm_mul #(
    parameter int A_W     = psnm_pkg::MUL_A_W,
    parameter int B_W     = psnm_pkg::MUL_B_W,
    parameter int DIGIT_W = psnm_pkg::MUL_DIGIT_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);
    import psnm_pkg::*;

    localparam int P_W    = A_W + B_W;
    localparam int PP_W   = A_W + DIGIT_W;
    localparam int DIGITS = B_W / DIGIT_W;
    localparam int CNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

    logic [A_W-1:0]   a_reg;
    logic [B_W-1:0]   b_reg;
    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   acc_next;
    logic [PP_W-1:0]  partial;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // One partial product per cycle, most significant digit of b first.
    always_comb
    begin
        partial  = a_reg * b_reg[B_W-1 -: DIGIT_W];
        acc_next = (acc_reg << DIGIT_W) + {{(P_W-PP_W){1'b0}}, partial};
    end

    // Sequencing of the digit passes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= b_reg << DIGIT_W;
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* hw/rtl/psnm_div.sv */
// Restoring divider, one quotient bit per cycle, for a quotient known to fit Q_W bits.
// Depends on psnm_pkg for its default widths.

module psnm_div #(
    parameter int D_W = psnm_pkg::DIV_D_W,
    parameter int Q_W = psnm_pkg::DIV_Q_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [D_W-1:0] rem_init,
    input  logic [Q_W-1:0] dividend_lo,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [Q_W-1:0] quotient
);
    import psnm_pkg::*;

    localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   rem_next;
    logic [D_W-1:0]   d_reg;
    logic [Q_W-1:0]   q_reg;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             q_bit;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        trial    = {rem_reg, q_reg[Q_W-1]};
        diff     = trial - {1'b0, d_reg};
        q_bit    = (trial >= {1'b0, d_reg});
        rem_next = q_bit ? diff[D_W-1:0] : trial[D_W-1:0];
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // The low dividend word shifts out as the quotient shifts in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            q_reg   <= dividend_lo;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[Q_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* tb/probe_step_noise_monitor_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for probe_step_noise_monitor: directed and random transactions.
// Depends on psnm_pkg and the monitor RTL; expected reports come from an in-file predictor.

module probe_step_noise_monitor_tb;
    import psnm_pkg::*;

    localparam int SAMPLE_W      = SAMPLE_BITS_DEF;
    localparam int FRAC_W        = FRAC_BITS_DEF;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int STEADY_ITEMS  = 120;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 100;

    // Action code 3 has no operation behind it; the block only reports.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [WEIGHT_W:0]          WEIGHT_ONE = (WEIGHT_W+1)'(1) << FRAC_W;
    localparam logic [WEIGHT_W-1:0]        WEIGHT_TWO = WEIGHT_W'(2) << FRAC_W;
    localparam logic [WEIGHT_W-1:0]        WEIGHT_SAT = '1;
    localparam logic signed [SUM_W-1:0]    SUM_HI     = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]    SUM_LO     = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SQ_W-1:0]            SQUARE_SAT = '1;
    localparam logic [COUNT_W-1:0]         COUNT_SAT  = '1;
    localparam logic [VAR_W-1:0]           VAR_SAT    = '1;
    localparam logic [LIMIT_W-1:0]         LIMIT_MAX  = '1;
    localparam logic [DECAY_W-1:0]         DECAY_MAX  = '1;

    typedef struct packed {
        verdict_t            verdict;
        logic [COUNT_W-1:0]  count;
        logic [VAR_W-1:0]    variance;
    } probe_report_t;

    // Block ports.
    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [ACTION_W-1:0]     action;
    logic [SAMPLE_W-1:0]     reading;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [VERDICT_W-1:0]    verdict;
    logic [COUNT_W-1:0]      evidence_count;
    logic [VAR_W-1:0]        step_variance;

    // Predictor copy of the configuration.
    logic [DECAY_W-1:0]      decay_q16;
    logic [LIMIT_W-1:0]      evidence_floor;
    logic [LIMIT_W-1:0]      spread_limit;

    // Predictor copy of the accumulated evidence.
    logic [SAMPLE_W-1:0]     last_reading;
    logic                    have_baseline;
    logic [WEIGHT_W-1:0]     weight_acc;
    logic signed [SUM_W-1:0] sum_acc;
    logic [SQ_W-1:0]         square_acc;
    logic [COUNT_W-1:0]      samples_seen;

    probe_report_t           predicted_reports[$];
    int                      mismatch_count = 0;
    int                      items_sent = 0;
    int                      cycle_count = 0;
    int                      stall_left = 0;
    int                      stall_pct = 4;
    bit                      idle_on = 1'b1;

    probe_step_noise_monitor i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .reading        (reading),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict),
        .evidence_count (evidence_count),
        .step_variance  (step_variance)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // floor(x * f / 65536) for the unsigned accumulators.
    function automatic logic [63:0] scale_q16(input logic [63:0] x, input logic [DECAY_W-1:0] f);
        logic [127:0] prod;
        prod = 128'(x) * 128'(f);
        return prod[79:16];
    endfunction

    // Applies one transaction to the evidence state and returns the report it produces.
    function automatic probe_report_t advance_probe(input logic [ACTION_W-1:0] act,
                                                    input logic [SAMPLE_W-1:0] rd);
        logic signed [SAMPLE_W:0] delta;
        logic [SAMPLE_W-1:0]      delta_mag;
        logic signed [SUM_W:0]    step_fix;
        logic signed [SUM_W:0]    sum_next;
        logic [WEIGHT_W:0]        weight_next;
        logic [SQ_W:0]            step_sq;
        logic [SQ_W:0]            square_next;
        logic [DECAY_W-1:0]       factor;
        logic [SUM_W-1:0]         sum_mag;
        logic [127:0]             qw;
        logic [127:0]             ss;
        logic [127:0]             num;
        logic [127:0]             quo;
        logic [127:0]             lw;
        logic                     positive;
        probe_report_t            rep;

        case (act)
            ACT_ADD:
            begin
                // The first reading after a clear only sets the baseline.
                if (have_baseline)
                begin
                    delta = $signed({1'b0, rd}) - $signed({1'b0, last_reading});
                    delta_mag = delta[SAMPLE_W] ? SAMPLE_W'(-delta) : SAMPLE_W'(delta);

                    weight_next = {1'b0, weight_acc} + WEIGHT_ONE;
                    weight_acc = weight_next[WEIGHT_W] ? WEIGHT_SAT : weight_next[WEIGHT_W-1:0];

                    step_fix = (SUM_W+1)'(delta);
                    step_fix = step_fix <<< FRAC_W;
                    sum_next = (SUM_W+1)'(sum_acc) + step_fix;
                    if (sum_next > SUM_HI)
                        sum_acc = SUM_HI;
                    else if (sum_next < SUM_LO)
                        sum_acc = SUM_LO;
                    else
                        sum_acc = sum_next[SUM_W-1:0];

                    step_sq = (SQ_W+1)'(delta_mag) * (SQ_W+1)'(delta_mag);
                    step_sq = step_sq << FRAC_W;
                    square_next = {1'b0, square_acc} + step_sq;
                    square_acc = square_next[SQ_W] ? SQUARE_SAT : square_next[SQ_W-1:0];
                end
                last_reading = rd;
                have_baseline = 1'b1;
                if (samples_seen != COUNT_SAT)
                    samples_seen = samples_seen + 1'b1;
            end
            ACT_DECAY:
            begin
                // Factors above one act as one; the signed sum scales in magnitude.
                factor = (decay_q16 > DECAY_ONE) ? DECAY_ONE : decay_q16;
                sum_mag = sum_acc[SUM_W-1] ? -sum_acc : sum_acc;
                sum_mag = SUM_W'(scale_q16(64'(sum_mag), factor));
                if (sum_acc[SUM_W-1])
                    sum_acc = -sum_mag;
                else
                    sum_acc = sum_mag;
                weight_acc = WEIGHT_W'(scale_q16(64'(weight_acc), factor));
                square_acc = SQ_W'(scale_q16(64'(square_acc), factor));
                samples_seen = COUNT_W'(scale_q16(64'(samples_seen), factor));
            end
            ACT_CLEAR:
            begin
                last_reading = '0;
                have_baseline = 1'b0;
                weight_acc = '0;
                sum_acc = '0;
                square_acc = '0;
                samples_seen = '0;
            end
            default:
            begin
            end
        endcase

        // Variance (QW - S^2) / W^2 in Q24.8, zero for small weight or non-positive spread.
        rep.count = samples_seen;
        rep.variance = '0;
        positive = 1'b0;
        num = '0;
        if (weight_acc >= WEIGHT_TWO)
        begin
            sum_mag = sum_acc[SUM_W-1] ? -sum_acc : sum_acc;
            qw = 128'(square_acc) * 128'(weight_acc);
            ss = 128'(sum_mag) * 128'(sum_mag);
            if (qw > ss)
            begin
                positive = 1'b1;
                num = qw - ss;
                quo = (num << VAR_FRAC) / (128'(weight_acc) * 128'(weight_acc));
                rep.variance = (quo > 128'(VAR_SAT)) ? VAR_SAT : quo[VAR_W-1:0];
            end
        end

        // The spread limit is compared squared, with the variance scaled to its 16 fraction bits.
        if (samples_seen < evidence_floor)
            rep.verdict = VERDICT_UNKNOWN;
        else
        begin
            lw = 128'(spread_limit) * 128'(weight_acc);
            if (positive && (lw * lw < (num << 16)))
                rep.verdict = VERDICT_NOISY;
            else
                rep.verdict = VERDICT_CONNECTED;
        end
        return rep;
    endfunction

    // A reading spread around a center, kept inside the converter range.
    function automatic logic [SAMPLE_W-1:0] pick_near(input int centre, input int amp);
        int v;
        v = centre - amp + int'($urandom_range(0, 2 * amp));
        if (v < 0)
            v = 0;
        if (v > (1 << SAMPLE_W) - 1)
            v = (1 << SAMPLE_W) - 1;
        return SAMPLE_W'(v);
    endfunction

    // Receiver side: random stall bursts while idling is enabled.
    always @(negedge clk)
    begin : receiver_stalls
        if (!idle_on || !rst_n)
            stall_left = 0;
        else if (stall_left > 0)
            stall_left = stall_left - 1;
        else if ($urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 17);
        out_stall <= (stall_left > 0);
    end

    // Each output transaction is compared with the oldest predicted report.
    always @(posedge clk)
    begin : check_reports
        probe_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_reports.size() == 0)
            begin
                $error("report with none predicted: verdict %0d count %0d variance %0d",
                       verdict, evidence_count, step_variance);
                mismatch_count++;
            end
            else
            begin
                want = predicted_reports.pop_front();
                if (verdict !== want.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", want.verdict, verdict);
                    mismatch_count++;
                end
                if (evidence_count !== want.count)
                begin
                    $error("evidence_count: expected %0d, got %0d", want.count, evidence_count);
                    mismatch_count++;
                end
                if (step_variance !== want.variance)
                begin
                    $error("step_variance: expected %0d, got %0d", want.variance, step_variance);
                    mismatch_count++;
                end
            end
        end
    end

    // Sends one input transaction, optionally after a random idle burst.
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SAMPLE_W-1:0] rd);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        action <= act;
        reading <= rd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted_reports.push_back(advance_probe(act, rd));
        items_sent++;
    endtask

    // Holds the sender until every predicted report has been taken.
    task automatic wait_for_reports();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_reports.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes all three registers on consecutive cycles; the block must be idle.
    task automatic apply_settings(input logic [DECAY_W-1:0] decay,
                                  input logic [LIMIT_W-1:0] min_count,
                                  input logic [LIMIT_W-1:0] spread_cap);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_DECAY;
        cfg_data <= CFG_DATA_W'(decay);
        @(negedge clk);
        cfg_index <= CFG_MIN_EVIDENCE;
        cfg_data <= min_count;
        @(negedge clk);
        cfg_index <= CFG_MAX_SPREAD;
        cfg_data <= spread_cap;
        @(negedge clk);
        cfg_write <= 1'b0;
        decay_q16 = decay;
        evidence_floor = min_count;
        spread_limit = spread_cap;
    endtask

    // Reset defaults: small weight, a flat step history and the unused action.
    task automatic test_reset_defaults();
        send_item(ACT_ADD, 12'd100);
        send_item(ACT_ADD, 12'd100);
        send_item(ACT_ADD, 12'd100);
        send_item(ACT_UNUSED, 12'hFFF);
    endtask

    // Full-scale steps with a zero spread limit, then decay by one and clear.
    task automatic test_extreme_readings();
        wait_for_reports();
        apply_settings(DECAY_ONE, '0, '0);
        send_item(ACT_ADD, 12'd0);
        send_item(ACT_ADD, 12'hFFF);
        send_item(ACT_ADD, 12'd0);
        send_item(ACT_ADD, 12'hFFF);
        send_item(ACT_DECAY, 12'd0);
        send_item(ACT_CLEAR, 12'hFFF);
    endtask

    // Negative step sums under factors above one, one half and zero.
    task automatic test_decay_factors();
        wait_for_reports();
        apply_settings(DECAY_MAX, '0, SPREAD_RESET);
        send_item(ACT_ADD, 12'd4000);
        send_item(ACT_ADD, 12'd3000);
        send_item(ACT_ADD, 12'd2900);
        send_item(ACT_ADD, 12'd2950);
        send_item(ACT_DECAY, 12'd0);
        wait_for_reports();
        apply_settings(17'h08000, '0, SPREAD_RESET);
        send_item(ACT_DECAY, 12'h555);
        wait_for_reports();
        apply_settings('0, '0, SPREAD_RESET);
        send_item(ACT_DECAY, 12'hAAA);
        send_item(ACT_ADD, 12'd2048);
    endtask

    // Largest evidence floor and spread limit, then a low floor that the count already exceeds.
    task automatic test_evidence_limits();
        wait_for_reports();
        apply_settings(DECAY_ONE, LIMIT_MAX, LIMIT_MAX);
        send_item(ACT_ADD, 12'hFFF);
        send_item(ACT_ADD, 12'd0);
        send_item(ACT_ADD, 12'd1);
        wait_for_reports();
        apply_settings(DECAY_ONE, 20'd3, LIMIT_MAX);
        send_item(ACT_ADD, 12'd5);
        send_item(ACT_ADD, 12'd9);
    endtask

    // Phases of random settings; mostly reading runs around a center, with some noise.
    task automatic test_random_traffic();
        int amps[8] = '{0, 1, 3, 8, 30, 120, 600, 4095};
        logic [DECAY_W-1:0] decay;
        logic [LIMIT_W-1:0] min_count;
        logic [LIMIT_W-1:0] spread_cap;
        int amp;
        int centre;
        int phase_len;
        int pick;
        int cap;

        while (items_sent < RANDOM_ITEMS - STEADY_ITEMS)
        begin
            wait_for_reports();
            case ($urandom_range(0, 9))
                0: decay = '0;
                1: decay = DECAY_ONE;
                2: decay = DECAY_W'($urandom_range(65537, 131071));
                default: decay = DECAY_W'($urandom_range(32768, 65535));
            endcase
            case ($urandom_range(0, 9))
                0: min_count = '0;
                1: min_count = LIMIT_MAX;
                2: min_count = LIMIT_W'($urandom_range(0, 1048575));
                default: min_count = LIMIT_W'($urandom_range(1, 40));
            endcase
            amp = amps[$urandom_range(0, 7)];
            cap = amp * 512 + 256;
            if (cap > 1048575)
                cap = 1048575;
            case ($urandom_range(0, 9))
                0: spread_cap = '0;
                1: spread_cap = LIMIT_MAX;
                2: spread_cap = LIMIT_W'($urandom_range(0, 1048575));
                default: spread_cap = LIMIT_W'($urandom_range(0, cap));
            endcase
            apply_settings(decay, min_count, spread_cap);

            idle_on = ($urandom_range(0, 3) != 0);
            stall_pct = $urandom_range(1, 8);
            if ($urandom_range(0, 1) == 1)
                send_item(ACT_CLEAR, SAMPLE_W'($urandom_range(0, 4095)));

            phase_len = $urandom_range(30, 120);
            centre = $urandom_range(0, 4095);
            for (int i = 0; i < phase_len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_item(ACT_DECAY, SAMPLE_W'($urandom_range(0, 4095)));
                else if (pick < 6)
                    send_item(ACT_CLEAR, SAMPLE_W'($urandom_range(0, 4095)));
                else if (pick < 8)
                    send_item(ACT_UNUSED, SAMPLE_W'($urandom_range(0, 4095)));
                else if (pick < 13)
                    send_item(ACT_ADD, SAMPLE_W'($urandom_range(0, 4095)));
                else
                    send_item(ACT_ADD, pick_near(centre, amp));
            end
        end
    endtask

    // Back-to-back transactions with no idling on either side.
    task automatic test_steady_stream();
        int centre;
        wait_for_reports();
        apply_settings(17'd61440, 20'd8, 20'd1024);
        idle_on = 1'b0;
        centre = $urandom_range(0, 4095);
        for (int i = 0; i < STEADY_ITEMS; i++)
        begin
            if (i % 40 == 39)
                send_item(ACT_DECAY, SAMPLE_W'($urandom_range(0, 4095)));
            else
                send_item(ACT_ADD, pick_near(centre, 8));
        end
    endtask

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("probe_step_noise_monitor: mismatch");
        $finish;
    end

    initial
    begin : run_tests
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_DECAY;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_ADD;
        reading = '0;

        // Predictor state after reset.
        decay_q16 = DECAY_ONE;
        evidence_floor = MIN_EVIDENCE_RESET;
        spread_limit = SPREAD_RESET;
        last_reading = '0;
        have_baseline = 1'b0;
        weight_acc = '0;
        sum_acc = '0;
        square_acc = '0;
        samples_seen = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_extreme_readings();
        test_decay_factors();
        test_evidence_limits();
        test_random_traffic();
        test_steady_stream();

        wait_for_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && predicted_reports.size() == 0)
            $display("probe_step_noise_monitor: match");
        else
            $display("probe_step_noise_monitor: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/psnm_pkg.sv
hw/rtl/psnm_mul.sv
hw/rtl/psnm_div.sv
hw/rtl/probe_step_noise_monitor.sv
tb/probe_step_noise_monitor_tb.sv
